// ===== rtl/haptic_pulse_alarm_controller_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Haptic pulse alarm controller assertion macros
// Clocked, reset-gated property checks used by the controller top level.
// ----------------------------------------------------------------------------
`ifndef HAPTIC_PULSE_ALARM_CONTROLLER_UNIT_MACROS_SVH
`define HAPTIC_PULSE_ALARM_CONTROLLER_UNIT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define HPAC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define HPAC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/hpac_pkg.sv =====
// ----------------------------------------------------------------------------
// hpac_pkg
// Types and constants of the haptic pulse alarm controller.
// ----------------------------------------------------------------------------
`default_nettype none

package hpac_pkg;

    localparam int unsigned CmdW    = 3;
    localparam int unsigned MsW     = 16;
    localparam int unsigned CodeW   = 8;
    localparam int unsigned StatusW = 2;
    localparam int unsigned PeriodW = MsW + 1;
    localparam int unsigned AddrW   = 4;
    localparam int unsigned DataW   = 32;

    localparam logic [CmdW-1:0] CMD_TICK       = 3'd0;
    localparam logic [CmdW-1:0] CMD_PULSE      = 3'd1;
    localparam logic [CmdW-1:0] CMD_CODE       = 3'd2;
    localparam logic [CmdW-1:0] CMD_DISCONNECT = 3'd3;
    localparam logic [CmdW-1:0] CMD_BUTTON     = 3'd4;

    localparam logic [StatusW-1:0] STATUS_OK      = 2'd0;
    localparam logic [StatusW-1:0] STATUS_INVALID = 2'd1;
    localparam logic [StatusW-1:0] STATUS_CAPPED  = 2'd2;

    localparam logic [1:0] REG_MAX_PULSE   = 2'd0;
    localparam logic [1:0] REG_ALARM_PULSE = 2'd1;
    localparam logic [1:0] REG_ALARM_GAP   = 2'd2;

    localparam logic [MsW-1:0] MAX_PULSE_RESET   = 16'd5000;
    localparam logic [MsW-1:0] ALARM_PULSE_RESET = 16'd200;
    localparam logic [MsW-1:0] ALARM_GAP_RESET   = 16'd800;

    localparam logic [CodeW-1:0] CODE_SHORT  = 8'd1;
    localparam logic [CodeW-1:0] CODE_MEDIUM = 8'd2;
    localparam logic [CodeW-1:0] CODE_LONG   = 8'd3;

    localparam logic [MsW-1:0] PULSE_SHORT_MS  = 16'd100;
    localparam logic [MsW-1:0] PULSE_MEDIUM_MS = 16'd300;
    localparam logic [MsW-1:0] PULSE_LONG_MS   = 16'd500;

    typedef struct packed {
        logic [CmdW-1:0]  cmd;
        logic [MsW-1:0]   duration_ms;
        logic [CodeW-1:0] code_byte;
        logic             flag;
    } t_in_item;

    typedef struct packed {
        logic               motor_drive;
        logic               alarm_active;
        logic               press_owned;
        logic [StatusW-1:0] status;
    } t_out_item;

endpackage

`default_nettype wire

// ===== rtl/haptic_pulse_alarm_controller_unit.sv =====
// ----------------------------------------------------------------------------
// haptic_pulse_alarm_controller_unit
// Event-driven vibration motor pulse timer with disconnect alarm.
// ----------------------------------------------------------------------------
// Takes one event per clock (tick, pulse request, wireless code, disconnect,
// button) while the result side takes them, and returns exactly one result per
// event. An accepted event lands in an input register; when the result side is
// not stalled, it is applied to the motor, pulse and alarm state and the result
// register is written. The result register decouples the two sides: a stalled
// result holds, and the input stage keeps one event waiting behind it. The user
// must write registers through the APB port only while no event is in flight;
// the block itself does not enforce it.
`default_nettype none

`include "haptic_pulse_alarm_controller_unit_macros.svh"

module haptic_pulse_alarm_controller_unit (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_in_valid,
    output logic                         o_in_stall,
    input  wire hpac_pkg::t_in_item      i_in_item,
    output logic                         o_out_valid,
    input  wire                          i_out_stall,
    output hpac_pkg::t_out_item          o_out_item,
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire  [hpac_pkg::AddrW-1:0]   paddr,
    input  wire  [hpac_pkg::DataW-1:0]   pwdata,
    output logic [hpac_pkg::DataW-1:0]   prdata,
    output logic                         pready
);
    import hpac_pkg::*;

    logic [MsW-1:0]     r_max_pulse;
    logic [MsW-1:0]     r_alarm_pulse;
    logic [MsW-1:0]     r_alarm_gap;

    logic               r_in_valid;
    t_in_item           r_in_item;
    logic               r_out_valid;
    t_out_item          r_out_item;

    logic               r_motor_on;
    logic [MsW-1:0]     r_pulse_remaining;
    logic               r_alarm_raised;
    logic               r_press_claimed;
    logic [PeriodW-1:0] r_alarm_countdown;

    logic               n_motor_on;
    logic [MsW-1:0]     n_pulse_remaining;
    logic               n_alarm_raised;
    logic               n_press_claimed;
    logic [PeriodW-1:0] n_alarm_countdown;
    t_out_item          n_out_item;

    logic               advance;
    logic               in_accept;
    logic               cfg_write;
    logic [1:0]         reg_index;

    logic [MsW-1:0]     limit;
    logic [PeriodW-1:0] period;
    logic [PeriodW-1:0] period_load;
    logic [MsW-1:0]     remaining_dec;
    logic [PeriodW-1:0] countdown_dec;
    logic               start;
    logic               fire;
    logic [MsW-1:0]     start_ms;
    logic               capped;

    assign advance    = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    assign pready    = 1'b1;
    assign reg_index = paddr[3:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        unique case (reg_index)
            REG_MAX_PULSE:   prdata = {{(DataW-MsW){1'b0}}, r_max_pulse};
            REG_ALARM_PULSE: prdata = {{(DataW-MsW){1'b0}}, r_alarm_pulse};
            REG_ALARM_GAP:   prdata = {{(DataW-MsW){1'b0}}, r_alarm_gap};
            default:         prdata = '0;
        endcase
    end

    assign limit         = (r_max_pulse == '0) ? MsW'(1) : r_max_pulse;
    assign period        = {1'b0, r_alarm_pulse} + {1'b0, r_alarm_gap};
    assign period_load   = (period == '0) ? PeriodW'(1) : period;
    assign remaining_dec = (r_pulse_remaining != '0) ? r_pulse_remaining - MsW'(1) : '0;
    assign countdown_dec = (r_alarm_countdown != '0) ? r_alarm_countdown - PeriodW'(1) : '0;

    always_comb begin
        n_motor_on        = r_motor_on;
        n_pulse_remaining = r_pulse_remaining;
        n_alarm_raised    = r_alarm_raised;
        n_press_claimed   = r_press_claimed;
        n_alarm_countdown = r_alarm_countdown;
        n_out_item        = '0;
        start             = 1'b0;
        fire              = 1'b0;
        start_ms          = r_in_item.duration_ms;
        capped            = 1'b0;

        unique case (r_in_item.cmd)
            CMD_TICK: begin
                if (r_motor_on) begin
                    n_pulse_remaining = remaining_dec;
                    if (remaining_dec == '0) begin
                        n_motor_on = 1'b0;
                    end
                end
                if (r_alarm_raised) begin
                    n_alarm_countdown = countdown_dec;
                    if (countdown_dec == '0) begin
                        fire = 1'b1;
                    end
                end
            end
            CMD_PULSE: begin
                start = 1'b1;
            end
            CMD_CODE: begin
                case (r_in_item.code_byte)
                    CODE_SHORT: begin
                        start    = 1'b1;
                        start_ms = PULSE_SHORT_MS;
                    end
                    CODE_MEDIUM: begin
                        start    = 1'b1;
                        start_ms = PULSE_MEDIUM_MS;
                    end
                    CODE_LONG: begin
                        start    = 1'b1;
                        start_ms = PULSE_LONG_MS;
                    end
                    default: begin
                        n_out_item.status = STATUS_INVALID;
                    end
                endcase
            end
            CMD_DISCONNECT: begin
                if (r_in_item.flag && !r_alarm_raised) begin
                    n_alarm_raised = 1'b1;
                    fire           = 1'b1;
                end
            end
            CMD_BUTTON: begin
                if (!r_in_item.flag) begin
                    n_out_item.press_owned = r_press_claimed;
                    n_press_claimed        = 1'b0;
                end else if (r_alarm_raised) begin
                    n_alarm_raised         = 1'b0;
                    n_alarm_countdown      = '0;
                    n_motor_on             = 1'b0;
                    n_pulse_remaining      = '0;
                    n_press_claimed        = 1'b1;
                    n_out_item.press_owned = 1'b1;
                end else begin
                    n_out_item.press_owned = r_press_claimed;
                end
            end
            default: begin
            end
        endcase

        if (fire) begin
            start             = 1'b1;
            start_ms          = r_alarm_pulse;
            n_alarm_countdown = period_load;
        end

        if (start) begin
            if (start_ms == '0) begin
                n_motor_on        = 1'b0;
                n_pulse_remaining = '0;
            end else begin
                capped            = start_ms > limit;
                n_motor_on        = 1'b1;
                n_pulse_remaining = capped ? limit : start_ms;
            end
        end
        if (capped) begin
            n_out_item.status = STATUS_CAPPED;
        end

        n_out_item.motor_drive  = n_motor_on;
        n_out_item.alarm_active = n_alarm_raised;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_pulse       <= MAX_PULSE_RESET;
            r_alarm_pulse     <= ALARM_PULSE_RESET;
            r_alarm_gap       <= ALARM_GAP_RESET;
            r_in_valid        <= 1'b0;
            r_out_valid       <= 1'b0;
            r_motor_on        <= 1'b0;
            r_pulse_remaining <= '0;
            r_alarm_raised    <= 1'b0;
            r_press_claimed   <= 1'b0;
            r_alarm_countdown <= '0;
        end else begin
            if (cfg_write) begin
                unique case (reg_index)
                    REG_MAX_PULSE:   r_max_pulse   <= pwdata[MsW-1:0];
                    REG_ALARM_PULSE: r_alarm_pulse <= pwdata[MsW-1:0];
                    REG_ALARM_GAP:   r_alarm_gap   <= pwdata[MsW-1:0];
                    default: begin
                    end
                endcase
            end
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
            if (r_in_valid && advance) begin
                r_motor_on        <= n_motor_on;
                r_pulse_remaining <= n_pulse_remaining;
                r_alarm_raised    <= n_alarm_raised;
                r_press_claimed   <= n_press_claimed;
                r_alarm_countdown <= n_alarm_countdown;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_item <= i_in_item;
        end
        if (r_in_valid && advance) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    `HPAC_ASSERT_SAME(a_motor_time, r_motor_on, r_pulse_remaining != '0, "motor on with no time")
    `HPAC_ASSERT_SAME(a_alarm_clear, !r_alarm_raised, r_alarm_countdown == '0, "stray countdown")
    `HPAC_ASSERT_NEXT(a_item_out, r_in_valid && !r_out_valid, r_out_valid, "event lost")

endmodule

`default_nettype wire
